### sv/tkz_pkg.sv
// ----------------------------------------------------------------------------
// tkz_pkg: shared types and constants of the command-line tokenizer
// Lexer states, result kinds, operator codes, byte constants and the result
// bundle that travels from the lexer front to the output back end.
// ----------------------------------------------------------------------------
package tkz_pkg;

  // Lexer state, one-hot
  typedef enum logic [7:0] {
    LX_NORMAL    = 8'b0000_0001,
    LX_SQUOTE    = 8'b0000_0010,
    LX_DQUOTE    = 8'b0000_0100,
    LX_BSLASH    = 8'b0000_1000,
    LX_DQ_BSLASH = 8'b0001_0000,
    LX_GT        = 8'b0010_0000,
    LX_TWO       = 8'b0100_0000,
    LX_TWO_GT    = 8'b1000_0000
  } lex_state_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_CHAR = 3'd0,
    KIND_WEND = 3'd1,
    KIND_OP   = 3'd2,
    KIND_OK   = 3'd3,
    KIND_ERR  = 3'd4
  } kind_t;

  // Operator codes carried in the value field
  localparam logic [7:0] OP_PIPE  = 8'd0;
  localparam logic [7:0] OP_AMP   = 8'd1;
  localparam logic [7:0] OP_GT    = 8'd2;
  localparam logic [7:0] OP_GTGT  = 8'd3;
  localparam logic [7:0] OP_2GT   = 8'd4;
  localparam logic [7:0] OP_2GTGT = 8'd5;

  // Bytes the lexer reacts to
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BTICK  = 8'h60;

  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
  } result_t;

  // All results one input item causes, in order; cnt of them are valid
  typedef struct packed {
    logic [1:0]                 cnt;
    result_t [MAX_RES-1:0]      res;
  } bundle_t;

  // Append one result to a bundle; a full bundle stays as it is
  function automatic bundle_t bundle_push(bundle_t b, kind_t k, logic [7:0] v);
    bundle_t o;
    o = b;
    if (b.cnt < 2'(MAX_RES)) begin
      o.res[b.cnt].kind  = k;
      o.res[b.cnt].value = v;
      o.cnt              = b.cnt + 2'd1;
    end
    return o;
  endfunction

endpackage

### sv/tkz_front.sv
// ----------------------------------------------------------------------------
// tkz_front: lexer front end
// Classifies each accepted byte or end-of-line against the lexer state and
// produces the bundle of results it causes, in the same cycle.
// ----------------------------------------------------------------------------
module tkz_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             mode,
  input  logic [7:0]       ch,
  output tkz_pkg::bundle_t bundle
);
  import tkz_pkg::*;

  lex_state_t state_r, state_nxt;
  logic       nonempty_r, nonempty_nxt;

  always_comb begin
    bundle_t b;
    logic    run_norm;
    logic    run_dq;
    b            = '0;
    run_norm     = 1'b0;
    run_dq       = 1'b0;
    state_nxt    = state_r;
    nonempty_nxt = nonempty_r;

    if (mode) begin
      case (state_r)
        LX_SQUOTE, LX_DQUOTE, LX_DQ_BSLASH: begin
          b = bundle_push(b, KIND_ERR, 8'd0);
        end
        LX_BSLASH: begin
          b = bundle_push(b, KIND_CHAR, CH_BSLASH);
          b = bundle_push(b, KIND_WEND, 8'd0);
          b = bundle_push(b, KIND_OK, 8'd0);
        end
        LX_GT: begin
          b = bundle_push(b, KIND_OP, OP_GT);
          b = bundle_push(b, KIND_OK, 8'd0);
        end
        LX_TWO: begin
          b = bundle_push(b, KIND_CHAR, CH_TWO);
          b = bundle_push(b, KIND_WEND, 8'd0);
          b = bundle_push(b, KIND_OK, 8'd0);
        end
        LX_TWO_GT: begin
          b = bundle_push(b, KIND_OP, OP_2GT);
          b = bundle_push(b, KIND_OK, 8'd0);
        end
        default: begin
          if (nonempty_r) b = bundle_push(b, KIND_WEND, 8'd0);
          b = bundle_push(b, KIND_OK, 8'd0);
        end
      endcase
      state_nxt    = LX_NORMAL;
      nonempty_nxt = 1'b0;
    end else begin
      // pending lookahead resolves first, then the byte may lex afresh
      case (state_r)
        LX_SQUOTE: begin
          if (ch == CH_SQUOTE) begin
            state_nxt = LX_NORMAL;
          end else begin
            b            = bundle_push(b, KIND_CHAR, ch);
            nonempty_nxt = 1'b1;
          end
        end
        LX_DQUOTE: begin
          run_dq = 1'b1;
        end
        LX_BSLASH: begin
          b            = bundle_push(b, KIND_CHAR, ch);
          nonempty_nxt = 1'b1;
          state_nxt    = LX_NORMAL;
        end
        LX_DQ_BSLASH: begin
          nonempty_nxt = 1'b1;
          if (ch inside {CH_DQUOTE, CH_BSLASH, CH_DOLLAR, CH_BTICK}) begin
            b         = bundle_push(b, KIND_CHAR, ch);
            state_nxt = LX_DQUOTE;
          end else begin
            b      = bundle_push(b, KIND_CHAR, CH_BSLASH);
            run_dq = 1'b1;
          end
        end
        LX_GT: begin
          if (ch == CH_GT) begin
            b         = bundle_push(b, KIND_OP, OP_GTGT);
            state_nxt = LX_NORMAL;
          end else begin
            b        = bundle_push(b, KIND_OP, OP_GT);
            run_norm = 1'b1;
          end
        end
        LX_TWO: begin
          if (ch == CH_GT) begin
            if (nonempty_r) b = bundle_push(b, KIND_WEND, 8'd0);
            nonempty_nxt = 1'b0;
            state_nxt    = LX_TWO_GT;
          end else begin
            b            = bundle_push(b, KIND_CHAR, CH_TWO);
            nonempty_nxt = 1'b1;
            run_norm     = 1'b1;
          end
        end
        LX_TWO_GT: begin
          if (ch == CH_GT) begin
            b         = bundle_push(b, KIND_OP, OP_2GTGT);
            state_nxt = LX_NORMAL;
          end else begin
            b        = bundle_push(b, KIND_OP, OP_2GT);
            run_norm = 1'b1;
          end
        end
        default: begin
          run_norm = 1'b1;
        end
      endcase

      if (run_dq) begin
        state_nxt = LX_DQUOTE;
        if (ch == CH_BSLASH) begin
          state_nxt = LX_DQ_BSLASH;
        end else if (ch == CH_DQUOTE) begin
          state_nxt = LX_NORMAL;
        end else begin
          b            = bundle_push(b, KIND_CHAR, ch);
          nonempty_nxt = 1'b1;
        end
      end

      if (run_norm) begin
        state_nxt = LX_NORMAL;
        if (ch == CH_BSLASH) begin
          state_nxt = LX_BSLASH;
        end else if (ch == CH_SQUOTE) begin
          state_nxt = LX_SQUOTE;
        end else if (ch == CH_DQUOTE) begin
          state_nxt = LX_DQUOTE;
        end else if (ch inside {CH_SPACE, [CH_TAB:CH_CR]}) begin
          if (nonempty_nxt) b = bundle_push(b, KIND_WEND, 8'd0);
          nonempty_nxt = 1'b0;
        end else if (ch == CH_PIPE || ch == CH_AMP || ch == CH_GT) begin
          if (nonempty_nxt) b = bundle_push(b, KIND_WEND, 8'd0);
          nonempty_nxt = 1'b0;
          if (ch == CH_PIPE)     b = bundle_push(b, KIND_OP, OP_PIPE);
          else if (ch == CH_AMP) b = bundle_push(b, KIND_OP, OP_AMP);
          else                   state_nxt = LX_GT;
        end else if (ch == CH_TWO) begin
          state_nxt = LX_TWO;
        end else begin
          b            = bundle_push(b, KIND_CHAR, ch);
          nonempty_nxt = 1'b1;
        end
      end
    end
    bundle = b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= LX_NORMAL;
      nonempty_r <= 1'b0;
    end else if (accept) begin
      state_r    <= state_nxt;
      nonempty_r <= nonempty_nxt;
    end
  end

endmodule

### sv/tkz_queue.sv
// ----------------------------------------------------------------------------
// tkz_queue: result bundle queue
// Small first-in first-out store of bundles between lexer and output stage.
// ----------------------------------------------------------------------------
module tkz_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  tkz_pkg::bundle_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output tkz_pkg::bundle_t rd_data,
  output logic             empty
);
  import tkz_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  bundle_t         mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      if (do_wr && !do_rd)      count_r <= count_r + 1'b1;
      else if (do_rd && !do_wr) count_r <= count_r - 1'b1;
    end
  end

endmodule

### sv/tkz_back.sv
// ----------------------------------------------------------------------------
// tkz_back: result sequencer
// Walks the head bundle into the output register one result per cycle while
// the output is not stalled, and marks the final result of each bundle.
// ----------------------------------------------------------------------------
module tkz_back (
  input  logic             clk,
  input  logic             rst_n,
  input  tkz_pkg::bundle_t head,
  input  logic             head_empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_value,
  output logic             out_last
);
  import tkz_pkg::*;

  logic [1:0] idx_r;
  logic       valid_r;
  kind_t      kind_r;
  logic [7:0] value_r;
  logic       last_r;
  logic       load, is_last;
  result_t    cur;

  assign load    = !head_empty && (!valid_r || out_ready);
  assign cur     = head.res[idx_r];
  assign is_last = (idx_r == head.cnt - 2'd1);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= is_last ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // hold payload while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= cur.kind;
      value_r <= cur.value;
      last_r  <= is_last;
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_value = value_r;
  assign out_last  = last_r;

endmodule

### sv/shell_command_line_tokenizer.sv
// ----------------------------------------------------------------------------
// shell_command_line_tokenizer: streaming shell word and operator tokenizer
// Splits a byte stream of command lines into word bytes, word ends, operator
// tokens and a per-line status.
// ----------------------------------------------------------------------------
// One byte or end-of-line marker is taken per transfer on the in_ stream and
// is lexed in the cycle it is accepted; its results (zero to three) go into
// a queue of QUEUE_DEPTH bundles and leave on the out_ stream at one result
// per cycle while out_tready is high, the last of each input item flagged
// by out_tlast. From an empty queue a result passes through the queue and
// output register before it is offered on out_. Input runs at one item per
// cycle while items average at most one result and out_tready is high, as
// the output register holds a single result; an item with two or three
// results holds the output stage for one transfer per result, after which
// a full queue drops in_tready. Items that produce nothing (quote marks, a
// pending backslash, a '2' or '>' held as lookahead) are never queued.
// Result kinds on out_tuser: 0 word byte, 1 word end, 2 operator, 3 line ok,
// 4 unclosed quote; out_tdata carries the byte or operator code
// (0 |, 1 &, 2 >, 3 >>, 4 2>, 5 2>>), zero otherwise.
module shell_command_line_tokenizer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ch
  input  logic [0:0] in_tuser,   // [0] mode: 1 = end of line
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] value
  output logic [2:0] out_tuser,  // [2:0] kind
  output logic       out_tlast
);
  import tkz_pkg::*;

  bundle_t fr_bundle;
  bundle_t q_head;
  logic    q_full, q_empty, q_pop;
  logic    in_fire, q_push;

  // accept whenever the queue has room; the lexer never stalls otherwise
  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;
  // drop items that decide nothing
  assign q_push    = in_fire && (fr_bundle.cnt != 2'd0);

  tkz_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_fire),
    .mode   (in_tuser[0]),
    .ch     (in_tdata),
    .bundle (fr_bundle)
  );

  tkz_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (fr_bundle),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  tkz_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_empty (q_empty),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (out_tuser),
    .out_value  (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

### sv/tkz_checker.sv
// ----------------------------------------------------------------------------
// tkz_checker: port-level checks of the tokenizer
// Watches the result stream for stalls, legal codes and line-status framing.
// ----------------------------------------------------------------------------
module tkz_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [2:0] out_tuser,
  input logic       out_tlast
);
  import tkz_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // line status closes the item that caused it
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_OK || out_tuser == KIND_ERR) |-> out_tlast)
    else $error("line status without tlast");

  // operator codes in range, and status and word end carry zero
  a_value_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_CHAR |->
      (out_tuser == KIND_OP && out_tdata <= OP_2GTGT) || out_tdata == 8'd0)
    else $error("bad value for kind");

  // kinds past unclosed quote never appear
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= KIND_ERR)
    else $error("bad kind");

  // reset empties the output stage
  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind shell_command_line_tokenizer tkz_checker u_tkz_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
